// ===== src/u8u16_pkg.sv =====
// ============================================================================
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ============================================================================
package u8u16_pkg;

    // Replacement unit for broken or invalid input: '?'
    localparam logic [15:0] QMARK = 16'h003F;

    // Default depth of the job queue between front and back parts
    localparam int QUEUE_DEPTH = 4;

    // Sequence length codes: continuation bytes still needed
    localparam logic [1:0] NEED_NONE = 2'd0;
    localparam logic [1:0] NEED_ONE  = 2'd1;
    localparam logic [1:0] NEED_TWO  = 2'd2;
    localparam logic [1:0] NEED_THREE = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } byte_item_t;

    typedef struct packed {
        logic [15:0] out_unit;
        logic        run_last;
        logic        text_end;
    } unit_item_t;

    // One byte's worth of output: q_count '?' units, then tail_count units
    typedef struct packed {
        logic [1:0]  q_count;
        logic [1:0]  tail_count;
        logic [15:0] tail_unit0;
        logic [15:0] tail_unit1;
        logic        last;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } queue_head_t;

endpackage

// ===== src/u8u16_front.sv =====
// ============================================================================
// u8u16_front
// Classify each byte, track the open sequence and build one output job.
// ============================================================================
module u8u16_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  u8u16_pkg::byte_item_t item,
    output logic                  push,
    output u8u16_pkg::job_t       job
);
    import u8u16_pkg::*;

    logic [1:0]  need_reg, need_next;
    logic [1:0]  have_reg, have_next;
    logic [20:0] partial_reg, partial_next;

    logic [7:0]  b;
    logic        is_cont;
    logic        f_tail;
    logic [15:0] f_unit;
    logic [1:0]  f_need;
    logic [20:0] f_partial;
    logic [1:0]  have_inc;
    logic [20:0] pp;
    logic [20:0] pt_off;
    logic        pt_bad;
    logic        pt_pair;
    logic [1:0]  nq;
    logic [1:0]  ntail;
    logic [15:0] t0;
    logic [15:0] t1;

    assign b       = item.in_byte;
    assign is_cont = (b[7:6] == 2'b10);

    // Handling of a byte that starts afresh
    always_comb
    begin
        f_tail    = 1'b1;
        f_unit    = QMARK;
        f_need    = NEED_NONE;
        f_partial = '0;
        priority if (!b[7])
        begin
            f_unit = {8'h00, b};
        end
        else if (b[7:5] == 3'b110)
        begin
            f_tail    = item.in_last;
            f_need    = item.in_last ? NEED_NONE : NEED_ONE;
            f_partial = item.in_last ? '0 : {16'h0000, b[4:0]};
        end
        else if (b[7:4] == 4'b1110)
        begin
            f_tail    = item.in_last;
            f_need    = item.in_last ? NEED_NONE : NEED_TWO;
            f_partial = item.in_last ? '0 : {17'h00000, b[3:0]};
        end
        else if (b[7:3] == 5'b11110)
        begin
            f_tail    = item.in_last;
            f_need    = item.in_last ? NEED_NONE : NEED_THREE;
            f_partial = item.in_last ? '0 : {18'h00000, b[2:0]};
        end
        else
        begin
            f_unit = QMARK;
        end
    end

    // Completed code point and its UTF-16 form
    assign have_inc = have_reg + 2'd1;
    assign pp       = {partial_reg[14:0], b[5:0]};
    assign pt_off   = pp - 21'h010000;
    assign pt_bad   = (pp > 21'h10FFFF) || ((pp >= 21'h00D800) && (pp <= 21'h00DFFF));
    assign pt_pair  = !pt_bad && (pp >= 21'h010000);

    always_comb
    begin
        nq           = 2'd0;
        ntail        = {1'b0, f_tail};
        t0           = f_unit;
        t1           = '0;
        need_next    = f_need;
        have_next    = 2'd0;
        partial_next = f_partial;
        priority if ((need_reg != NEED_NONE) && is_cont)
        begin
            priority if (have_inc == need_reg)
            begin
                need_next    = NEED_NONE;
                partial_next = '0;
                if (pt_bad)
                begin
                    ntail = 2'd1;
                    t0    = QMARK;
                end
                else if (pt_pair)
                begin
                    ntail = 2'd2;
                    t0    = {6'b110110, pt_off[19:10]};
                    t1    = {6'b110111, pt_off[9:0]};
                end
                else
                begin
                    ntail = 2'd1;
                    t0    = pp[15:0];
                end
            end
            else if (item.in_last)
            begin
                // text ended inside the sequence: flush lead and buffered bytes
                nq           = have_inc + 2'd1;
                ntail        = 2'd0;
                need_next    = NEED_NONE;
                partial_next = '0;
            end
            else
            begin
                ntail        = 2'd0;
                need_next    = need_reg;
                have_next    = have_inc;
                partial_next = pp;
            end
        end
        else if (need_reg != NEED_NONE)
        begin
            // broken sequence: flush it, then take this byte afresh
            nq = have_reg + 2'd1;
        end
        else
        begin
            nq = 2'd0;
        end
    end

    assign push = accept && ((nq != 2'd0) || (ntail != 2'd0));

    always_comb
    begin
        job.q_count    = nq;
        job.tail_count = ntail;
        job.tail_unit0 = t0;
        job.tail_unit1 = t1;
        job.last       = item.in_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_reg    <= NEED_NONE;
            have_reg    <= 2'd0;
            partial_reg <= '0;
        end
        else if (accept)
        begin
            need_reg    <= need_next;
            have_reg    <= have_next;
            partial_reg <= partial_next;
        end
    end

endmodule

// ===== src/u8u16_queue.sv =====
// ============================================================================
// u8u16_queue
// Short job queue between the front and back parts.
// ============================================================================
module u8u16_queue #(
    parameter int DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  u8u16_pkg::job_t          push_job,
    input  logic                     pop,
    output logic                     full,
    output u8u16_pkg::queue_head_t   head
);
    import u8u16_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t            slot_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.job   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/u8u16_back.sv =====
// ============================================================================
// u8u16_back
// Unroll one job into code units, one per cycle while not stalled, into the output register.
// ============================================================================
module u8u16_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  u8u16_pkg::queue_head_t  head,
    output logic                    pop,
    output logic                    unit_valid,
    input  logic                    unit_stall,
    output u8u16_pkg::unit_item_t   unit_item
);
    import u8u16_pkg::*;

    logic [1:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    unit_item_t  out_item_reg, out_item_next;

    logic        emit;
    logic [2:0]  total;
    logic        is_final;
    logic [15:0] unit;

    assign total    = {1'b0, head.job.q_count} + {1'b0, head.job.tail_count};
    assign is_final = ({1'b0, idx_reg} == (total - 3'd1));
    assign emit     = head.valid && (!out_valid_reg || !unit_stall);
    assign pop      = emit && is_final;

    always_comb
    begin
        priority if (idx_reg < head.job.q_count)
        begin
            unit = QMARK;
        end
        else if (idx_reg == head.job.q_count)
        begin
            unit = head.job.tail_unit0;
        end
        else
        begin
            unit = head.job.tail_unit1;
        end
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && unit_stall;
        if (emit)
        begin
            idx_next               = is_final ? 2'd0 : idx_reg + 2'd1;
            out_valid_next         = 1'b1;
            out_item_next.out_unit = unit;
            out_item_next.run_last = is_final;
            out_item_next.text_end = is_final && head.job.last;
        end
    end

    assign unit_valid = out_valid_reg;
    assign unit_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

endmodule

// ===== src/utf8_to_utf16_transcoder.sv =====
// ============================================================================
// utf8_to_utf16_transcoder
// UTF-8 byte stream in, UTF-16 code unit stream out.
// ============================================================================
// The block takes one UTF-8 byte per cycle whenever its job queue has room
// and delivers one UTF-16 code unit per cycle whenever the sink does not
// stall. A byte may cause zero to four units: a lead byte or an incomplete
// continuation gives none, an ASCII byte or a code point below 0x10000 gives
// one, a supplementary code point gives a surrogate pair, and a broken or
// truncated sequence gives one '?' per lead and buffered continuation byte
// (plus the breaking byte's own result). The output rate of one unit per
// cycle sets the sustained throughput: bytes that expand to several units
// hold the back part while their units go out, and the QUEUE_DEPTH-entry job
// queue soaks up such bursts before byte_stall rises. The first unit of a
// byte reaches the output through the queue and the output register: the
// taking edge writes its job into the queue, and once the job is at the
// head and the output register is free, an edge loads its unit there.
// Each unit carries run_last on the final unit of its byte and text_end on
// the final unit of a byte flagged in_last; the sequence state is clear
// after such a byte, so the next byte opens a new text.
module utf8_to_utf16_transcoder #(
    parameter int QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  u8u16_pkg::byte_item_t  byte_item,
    output logic                   unit_valid,
    input  logic                   unit_stall,
    output u8u16_pkg::unit_item_t  unit_item
);
    import u8u16_pkg::*;

    logic        byte_accept;
    logic        push;
    logic        pop;
    logic        full;
    job_t        job;
    queue_head_t head;

    // Stall the source only when the queue has no room for another job
    assign byte_stall  = full;
    assign byte_accept = byte_valid && !byte_stall;

    // Front: classify the byte and advance the sequence state
    u8u16_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (byte_accept),
        .item   (byte_item),
        .push   (push),
        .job    (job)
    );

    // Queue: decouple byte intake from unit delivery
    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (job),
        .pop      (pop),
        .full     (full),
        .head     (head)
    );

    // Back: unroll each job into units behind the output register
    u8u16_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .unit_valid (unit_valid),
        .unit_stall (unit_stall),
        .unit_item  (unit_item)
    );

    // Never write a job into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("job pushed into full queue");

    // Never retire a job that is not there
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("job popped from empty queue");

    // The end of the text is always the final unit of its byte
    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (unit_valid && unit_item.text_end) |-> unit_item.run_last)
        else $error("text_end without run_last");

    // A queued job always carries at least one unit
    a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        head.valid |-> ((head.job.q_count != 2'd0) || (head.job.tail_count != 2'd0)))
        else $error("empty job in queue");

endmodule

// ===== verif/utf8_to_utf16_transcoder_test.sv =====
// ============================================================================
// utf8_to_utf16_transcoder_test
// Self-checking testbench for the UTF-8 to UTF-16 transcoder.
// ============================================================================
// Feeds a stimulus table of hand-picked bytes, then a stream of random text
// made mostly of well-formed characters with broken sequences and noise mixed
// in. A behavioral decoder in the testbench predicts the code units for every
// accepted byte. Each delivered unit is compared field by field against the
// oldest prediction. Both ports idle at random; one phase runs without any
// idling at all.
// ============================================================================
module utf8_to_utf16_transcoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import u8u16_pkg::*;

    // Number of random bytes after the table
    localparam int RANDOM_BYTES = 144;
    // Cycles to keep watching after the last predicted unit has arrived
    localparam int DRAIN_CYCLES = 16;
    // Hard stop for a hung run, far beyond the slowest legal run
    localparam int TIMEOUT_NS = 1_000_000;

    // One row of the stimulus table. When typed is set, the expected units
    // are written out in the row (first unit leftmost); otherwise the
    // decoder below supplies them.
    typedef struct packed {
        logic [7:0]       in_byte;
        logic             in_last;
        logic             typed;
        logic [2:0]       n_units;
        logic [0:3][15:0] units;
    } stim_row_t;

    localparam int N_ROWS = 26;
    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        // extremes of ASCII, right after reset
        '{8'h00, 1'b0, 1'b1, 3'd1, 64'h0000_0000_0000_0000},
        '{8'h7F, 1'b0, 1'b1, 3'd1, 64'h007F_0000_0000_0000},
        // stray continuation, invalid lead bytes, end of text on one of them
        '{8'h80, 1'b0, 1'b1, 3'd1, 64'h003F_0000_0000_0000},
        '{8'hFF, 1'b0, 1'b1, 3'd1, 64'h003F_0000_0000_0000},
        '{8'hF8, 1'b1, 1'b1, 3'd1, 64'h003F_0000_0000_0000},
        // two-byte character
        '{8'hC3, 1'b0, 1'b1, 3'd0, 64'h0000_0000_0000_0000},
        '{8'hA9, 1'b0, 1'b0, 3'd0, 64'h0000_0000_0000_0000},
        // three-byte sequence broken by an ASCII byte
        '{8'hE2, 1'b0, 1'b1, 3'd0, 64'h0000_0000_0000_0000},
        '{8'h82, 1'b0, 1'b1, 3'd0, 64'h0000_0000_0000_0000},
        '{8'h41, 1'b0, 1'b1, 3'd3, 64'h003F_003F_0041_0000},
        // highest legal code point, a surrogate pair
        '{8'hF4, 1'b0, 1'b1, 3'd0, 64'h0000_0000_0000_0000},
        '{8'h8F, 1'b0, 1'b1, 3'd0, 64'h0000_0000_0000_0000},
        '{8'hBF, 1'b0, 1'b1, 3'd0, 64'h0000_0000_0000_0000},
        '{8'hBF, 1'b0, 1'b0, 3'd0, 64'h0000_0000_0000_0000},
        // encoded surrogate code point
        '{8'hED, 1'b0, 1'b1, 3'd0, 64'h0000_0000_0000_0000},
        '{8'hA0, 1'b0, 1'b1, 3'd0, 64'h0000_0000_0000_0000},
        '{8'h80, 1'b0, 1'b1, 3'd1, 64'h003F_0000_0000_0000},
        // code point above the Unicode range, completed on end of text
        '{8'hF7, 1'b0, 1'b1, 3'd0, 64'h0000_0000_0000_0000},
        '{8'hBF, 1'b0, 1'b1, 3'd0, 64'h0000_0000_0000_0000},
        '{8'hBF, 1'b0, 1'b1, 3'd0, 64'h0000_0000_0000_0000},
        '{8'hBF, 1'b1, 1'b1, 3'd1, 64'h003F_0000_0000_0000},
        // text ends on a lead byte
        '{8'hF0, 1'b1, 1'b1, 3'd1, 64'h003F_0000_0000_0000},
        // four-byte sequence broken by a lead byte that also ends the text:
        // the most units one byte can cause
        '{8'hF0, 1'b0, 1'b1, 3'd0, 64'h0000_0000_0000_0000},
        '{8'h90, 1'b0, 1'b1, 3'd0, 64'h0000_0000_0000_0000},
        '{8'h80, 1'b0, 1'b1, 3'd0, 64'h0000_0000_0000_0000},
        '{8'hC0, 1'b1, 1'b1, 3'd4, 64'h003F_003F_003F_003F}
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       byte_valid;
    logic       byte_stall;
    byte_item_t byte_item;
    logic       unit_valid;
    logic       unit_stall = 1'b0;
    unit_item_t unit_item;

    // Decoder state, mirrors the sequence tracking of the block
    logic [1:0]  seq_need;
    logic [1:0]  seq_have;
    logic [20:0] seq_point;
    logic [15:0] decoded_units[$];

    // Units still owed by the block, oldest first
    unit_item_t units_due[$];
    int         unit_errors = 0;

    // Idling odds in percent, changed per phase by the stimulus
    int src_gap_pct    = 0;
    int sink_stall_pct = 0;
    int sink_hold_left = 0;

    utf8_to_utf16_transcoder u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .unit_valid (unit_valid),
        .unit_stall (unit_stall),
        .unit_item  (unit_item)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Mostly short idle stretches, now and then a long one
    function automatic int idle_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    // ------------------------------------------------------------------
    // Decoder
    // ------------------------------------------------------------------

    // Drop the open sequence: one '?' for the lead and each buffered byte.
    function automatic void abandon_sequence();
        for (int i = 0; i <= seq_have; i++)
            decoded_units.push_back(QMARK);
        seq_need  = NEED_NONE;
        seq_have  = '0;
        seq_point = '0;
    endfunction

    // Handle a byte with no sequence open.
    function automatic void start_fresh(logic [7:0] b, logic last);
        if (b < 8'h80) begin
            decoded_units.push_back({8'h00, b});
        end
        else if (b < 8'hC0 || b >= 8'hF8) begin
            decoded_units.push_back(QMARK);
        end
        else begin
            if (b < 8'hE0) begin
                seq_need  = NEED_ONE;
                seq_point = {16'h0, b[4:0]};
            end
            else if (b < 8'hF0) begin
                seq_need  = NEED_TWO;
                seq_point = {17'h0, b[3:0]};
            end
            else begin
                seq_need  = NEED_THREE;
                seq_point = {18'h0, b[2:0]};
            end
            seq_have = '0;
            // a lead byte that ends the text can never complete
            if (last)
                abandon_sequence();
        end
    endfunction

    // Advance the decoder by one byte and leave its units in decoded_units.
    function automatic void decode_byte(byte_item_t item);
        logic [20:0] v;

        decoded_units = {};
        if (seq_need == NEED_NONE) begin
            start_fresh(item.in_byte, item.in_last);
        end
        else if (item.in_byte[7:6] == 2'b10) begin
            seq_point = {seq_point[14:0], item.in_byte[5:0]};
            seq_have  = seq_have + 2'd1;
            if (seq_have >= seq_need) begin
                // out of range or surrogate: one '?' for the whole sequence
                if (seq_point > 21'h10FFFF ||
                    (seq_point >= 21'h00D800 && seq_point <= 21'h00DFFF)) begin
                    decoded_units.push_back(QMARK);
                end
                else if (seq_point < 21'h010000) begin
                    decoded_units.push_back(seq_point[15:0]);
                end
                else begin
                    v = seq_point - 21'h010000;
                    decoded_units.push_back(16'hD800 + {6'h0, v[19:10]});
                    decoded_units.push_back(16'hDC00 + {6'h0, v[9:0]});
                end
                seq_need  = NEED_NONE;
                seq_have  = '0;
                seq_point = '0;
            end
            else if (item.in_last) begin
                abandon_sequence();
            end
        end
        else begin
            // broken sequence: flush it, then take the byte afresh
            abandon_sequence();
            start_fresh(item.in_byte, item.in_last);
        end
    endfunction

    // ------------------------------------------------------------------
    // Byte side
    // ------------------------------------------------------------------

    // Offer one byte, hold it until taken, then queue its expected units.
    // Entered and left at a falling edge.
    task automatic send_byte(input byte_item_t item, input logic typed,
                             input logic [2:0] n_units,
                             input logic [0:3][15:0] units);
        unit_item_t due;
        int         gap;

        gap = ($urandom_range(0, 99) < src_gap_pct) ? idle_length() : 0;
        if (gap != 0) begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= item;
        do
            @(posedge clk);
        while (byte_stall);

        decode_byte(item);
        // typed rows override the decoder, which still advances its state
        if (typed) begin
            decoded_units = {};
            for (int i = 0; i < n_units; i++)
                decoded_units.push_back(units[i]);
        end
        foreach (decoded_units[k]) begin
            due.out_unit = decoded_units[k];
            due.run_last = (k == decoded_units.size() - 1);
            due.text_end = due.run_last && item.in_last;
            units_due.push_back(due);
        end
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Unit side: random stall, then check every unit taken
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (sink_hold_left != 0) begin
            unit_stall     <= 1'b1;
            sink_hold_left <= sink_hold_left - 1;
        end
        else if ($urandom_range(0, 99) < sink_stall_pct) begin
            unit_stall     <= 1'b1;
            sink_hold_left <= idle_length() - 1;
        end
        else begin
            unit_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        unit_item_t want;

        if (rst_n && unit_valid && !unit_stall) begin
            if (units_due.size() == 0) begin
                if (unit_errors < 10)
                    $display("%0t: unexpected unit %h run_last %b text_end %b",
                             $realtime, unit_item.out_unit, unit_item.run_last,
                             unit_item.text_end);
                unit_errors++;
            end
            else begin
                want = units_due.pop_front();
                if (unit_item.out_unit !== want.out_unit ||
                    unit_item.run_last !== want.run_last ||
                    unit_item.text_end !== want.text_end) begin
                    if (unit_errors < 10)
                        $display("%0t: unit mismatch: expected %h/%b/%b got %h/%b/%b",
                                 $realtime, want.out_unit, want.run_last,
                                 want.text_end, unit_item.out_unit,
                                 unit_item.run_last, unit_item.text_end);
                    unit_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin
        byte_item_t random_bytes[$];
        byte_item_t item;
        logic [7:0] chunk[$];
        logic [7:0] lead;
        int         kind;
        int         len;

        rst_n      = 1'b0;
        byte_valid = 1'b0;
        byte_item  = '0;
        seq_need   = NEED_NONE;
        seq_have   = '0;
        seq_point  = '0;

        // Build the random text: mostly whole characters, some cut short,
        // some stray continuations, invalid bytes and plain noise.
        while (random_bytes.size() < RANDOM_BYTES) begin
            chunk = {};
            kind  = $urandom_range(0, 11);
            if (kind <= 2) begin
                chunk.push_back(8'($urandom_range(0, 127)));
            end
            else if (kind <= 9) begin
                len = (kind <= 4) ? 2 : (kind <= 7) ? 3 : 4;
                case (len)
                    2:       lead = 8'hC0 | 8'($urandom_range(0, 31));
                    3:       lead = 8'hE0 | 8'($urandom_range(0, 15));
                    default: lead = 8'hF0 | 8'($urandom_range(0, 7));
                endcase
                // steer some three-byte characters into the surrogate range
                if (len == 3 && $urandom_range(0, 3) == 0)
                    lead = 8'hED;
                chunk.push_back(lead);
                for (int i = 1; i < len; i++)
                    chunk.push_back(8'h80 | 8'($urandom_range(0, 63)));
                // cut the sequence short so the next byte usually breaks it
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(1, len - 1))
                        void'(chunk.pop_back());
            end
            else if (kind == 10) begin
                chunk.push_back(8'($urandom_range(0, 255)));
            end
            else begin
                chunk.push_back($urandom_range(0, 1) ?
                                8'($urandom_range(8'hF8, 8'hFF)) :
                                8'h80 | 8'($urandom_range(0, 63)));
            end
            foreach (chunk[i]) begin
                item.in_byte = chunk[i];
                // end the text now and then, mostly on a character boundary
                item.in_last = ($urandom_range(0, 29) == 0) ||
                               (i == chunk.size() - 1 && $urandom_range(0, 9) == 0);
                random_bytes.push_back(item);
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the table with light idling on both sides
        src_gap_pct    = 15;
        sink_stall_pct = 15;
        for (int r = 0; r < N_ROWS; r++) begin
            item.in_byte = DIRECTED_ROWS[r].in_byte;
            item.in_last = DIRECTED_ROWS[r].in_last;
            send_byte(item, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].n_units,
                      DIRECTED_ROWS[r].units);
        end

        // Random text in three phases: back to back, mixed idling, then a
        // slow sink that keeps the job queue full.
        foreach (random_bytes[i]) begin
            if (i == 0) begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end
            else if (i == RANDOM_BYTES / 3) begin
                src_gap_pct    = 25;
                sink_stall_pct = 25;
            end
            else if (i == 2 * RANDOM_BYTES / 3) begin
                // hold the byte side until the block has delivered everything
                byte_valid <= 1'b0;
                do
                    @(negedge clk);
                while (units_due.size() != 0);
                src_gap_pct    = 10;
                sink_stall_pct = 60;
            end
            send_byte(random_bytes[i], 1'b0, 3'd0, '0);
        end
        byte_valid <= 1'b0;

        // Drain, then watch a little longer for stray units
        while (units_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (unit_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("timeout with %0d units outstanding", units_due.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
